@@ rtl/core/fsr_pkg.sv @@
// shared types, constants and compare functions for the fall token stream recognizer
`timescale 1ns / 1ps

package fsr_pkg;

   localparam int LINE_LIMIT = 256;
   localparam int COUNT_WIDTH = 32;
   localparam int HIST_DEPTH = 10;
   localparam int WIN_DEPTH = HIST_DEPTH + 1;
   localparam int HEAD_DEPTH = 11;
   localparam int HEAD_IDX_W = $clog2(HEAD_DEPTH);
   localparam int LINE_CNT_W = $clog2(LINE_LIMIT);
   localparam int OUT_COUNT_W = 32;
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   typedef logic [WIN_DEPTH-1:0][7:0] win_type;
   typedef logic [HIST_DEPTH-1:0][7:0] hist_type;
   typedef logic [HEAD_DEPTH-1:0][7:0] head_type;

   // device tag that opens every stream marker
   localparam logic [31:0] MARK_PREFIX = 32'h4B32_3330;

   // tokens right aligned, newest character in byte 0
   localparam win_type TOK_PFX_NOFALL = {MARK_PREFIX, ",NOFALL"};
   localparam win_type TOK_PFX_NORMAL = {MARK_PREFIX, ",NORMAL"};
   localparam win_type TOK_PFX_ZERO = 88'({MARK_PREFIX, ",0"});
   localparam win_type TOK_PFX_FALL = 88'({MARK_PREFIX, ",FALL"});
   localparam win_type TOK_PFX_ONE = 88'({MARK_PREFIX, ",1"});
   localparam win_type TOK_NOFALL = 88'("NOFALL");
   localparam win_type TOK_NORMAL = 88'("NORMAL");
   localparam win_type TOK_FALL = 88'("FALL");
   localparam win_type TOK_ZERO = 88'("0");
   localparam win_type TOK_ONE = 88'("1");

   localparam int LEN_PFX_NOFALL = 11;
   localparam int LEN_PFX_NORMAL = 11;
   localparam int LEN_PFX_ZERO = 6;
   localparam int LEN_PFX_FALL = 9;
   localparam int LEN_PFX_ONE = 6;
   localparam int LEN_NOFALL = 6;
   localparam int LEN_NORMAL = 6;
   localparam int LEN_FALL = 4;
   localparam int LEN_ZERO = 1;
   localparam int LEN_ONE = 1;

   typedef enum logic [2:0] {
      EV_STREAM_NORMAL = 3'd0,
      EV_STREAM_FALL   = 3'd1,
      EV_LINE_NORMAL   = 3'd2,
      EV_LINE_FALL     = 3'd3,
      EV_LINE_UNKNOWN  = 3'd4,
      EV_LINE_TOO_LONG = 3'd5
   } event_kind_type;

   typedef struct packed {
      logic hit;
      logic fall;
   } scan_res_type;

   typedef struct packed {
      logic           emit;
      event_kind_type kind;
   } line_res_type;

   typedef struct packed {
      event_kind_type          kind;
      logic                    status_valid;
      logic                    fall_seen;
      logic [OUT_COUNT_W-1:0]  frame_total;
      logic [OUT_COUNT_W-1:0]  error_total;
      logic                    last_in_run;
   } result_type;

   typedef struct packed {
      logic [1:0] n;
      result_type w0;
      result_type w1;
   } push_type;

   function automatic logic [7:0] fold_up(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   function automatic logic is_kept(input logic [7:0] u);
      return (u >= 8'h41 && u <= 8'h5A) || (u >= 8'h30 && u <= 8'h39) ||
             u == 8'h2C || u == 8'h3A || u == 8'h5F || u == 8'h2D;
   endfunction

   // window ends with token of length n
   function automatic logic tail_match(input win_type win, input win_type tok, input int n);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if (i < n && win[i] != tok[i]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // case-insensitive equality of head[0..len) with token of length n
   function automatic logic head_match(input head_type head, input logic [LINE_CNT_W-1:0] len,
                                       input win_type tok, input int n);
      logic ok;
      ok = (len == LINE_CNT_W'(n));
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         if (i < n) begin
            if (fold_up(head[i]) != tok[n-1-i]) begin
               ok = 1'b0;
            end
         end
      end
      return ok;
   endfunction

endpackage

@@ rtl/core/fsr_scan.sv @@
// stream scanner: history of kept characters and marker compare
`timescale 1ns / 1ps

module fsr_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           rx_byte,
   output fsr_pkg::scan_res_type scan_res
);
   import fsr_pkg::*;

   hist_type hist_ff;
   hist_type hist_in;
   logic [7:0] u;
   logic kept;
   win_type win;
   logic norm_hit;
   logic fall_hit;

   always_comb begin
      u = fold_up(rx_byte);
      kept = is_kept(u);
      win = {hist_ff, u};
      norm_hit = tail_match(win, TOK_PFX_NOFALL, LEN_PFX_NOFALL) ||
                 tail_match(win, TOK_PFX_NORMAL, LEN_PFX_NORMAL) ||
                 tail_match(win, TOK_PFX_ZERO, LEN_PFX_ZERO);
      fall_hit = tail_match(win, TOK_PFX_FALL, LEN_PFX_FALL) ||
                 tail_match(win, TOK_PFX_ONE, LEN_PFX_ONE);
      scan_res.hit = kept && (norm_hit || fall_hit);
      scan_res.fall = !norm_hit;
      hist_in = hist_ff;
      if (take && kept) begin
         if (norm_hit || fall_hit) begin
            hist_in = '0;
         end else begin
            hist_in = {hist_ff[HIST_DEPTH-2:0], u};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else begin
         hist_ff <= hist_in;
      end
   end

endmodule

@@ rtl/core/fsr_line.sv @@
// line parser: line bookkeeping, head store and token compare
`timescale 1ns / 1ps

module fsr_line (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           rx_byte,
   output fsr_pkg::line_res_type line_res
);
   import fsr_pkg::*;

   logic [LINE_CNT_W-1:0] line_count_ff, line_count_in;
   logic [LINE_CNT_W-1:0] text_length_ff, text_length_in;
   logic [LINE_CNT_W-1:0] nonblank_end_ff, nonblank_end_in;
   logic zero_seen_ff, zero_seen_in;
   head_type head_ff;

   logic is_lf;
   logic is_cr;
   logic room;
   logic norm_hit;
   logic fall_hit;
   logic head_wr;

   always_comb begin
      is_lf = (rx_byte == CHAR_LF);
      is_cr = (rx_byte == CHAR_CR);
      room = line_count_ff < LINE_CNT_W'(LINE_LIMIT - 1);
      norm_hit = head_match(head_ff, nonblank_end_ff, TOK_PFX_NOFALL, LEN_PFX_NOFALL) ||
                 head_match(head_ff, nonblank_end_ff, TOK_NOFALL, LEN_NOFALL) ||
                 head_match(head_ff, nonblank_end_ff, TOK_PFX_NORMAL, LEN_PFX_NORMAL) ||
                 head_match(head_ff, nonblank_end_ff, TOK_NORMAL, LEN_NORMAL) ||
                 head_match(head_ff, nonblank_end_ff, TOK_ZERO, LEN_ZERO);
      fall_hit = head_match(head_ff, nonblank_end_ff, TOK_PFX_FALL, LEN_PFX_FALL) ||
                 head_match(head_ff, nonblank_end_ff, TOK_FALL, LEN_FALL) ||
                 head_match(head_ff, nonblank_end_ff, TOK_ONE, LEN_ONE);

      if (is_lf) begin
         line_res.emit = (text_length_ff != '0);
         if (norm_hit) begin
            line_res.kind = EV_LINE_NORMAL;
         end else if (fall_hit) begin
            line_res.kind = EV_LINE_FALL;
         end else begin
            line_res.kind = EV_LINE_UNKNOWN;
         end
      end else begin
         line_res.emit = !is_cr && !room;
         line_res.kind = EV_LINE_TOO_LONG;
      end

      line_count_in = line_count_ff;
      text_length_in = text_length_ff;
      nonblank_end_in = nonblank_end_ff;
      zero_seen_in = zero_seen_ff;
      head_wr = 1'b0;
      if (take && !is_cr) begin
         if (is_lf || !room) begin
            line_count_in = '0;
            text_length_in = '0;
            nonblank_end_in = '0;
            zero_seen_in = 1'b0;
         end else begin
            line_count_in = line_count_ff + 1'b1;
            if (rx_byte == CHAR_NUL) begin
               zero_seen_in = 1'b1;
            end else if (!zero_seen_ff) begin
               head_wr = text_length_ff < LINE_CNT_W'(HEAD_DEPTH);
               text_length_in = text_length_ff + 1'b1;
               if (rx_byte != CHAR_SPACE && rx_byte != CHAR_TAB) begin
                  nonblank_end_in = text_length_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= '0;
         text_length_ff <= '0;
         nonblank_end_ff <= '0;
         zero_seen_ff <= 1'b0;
      end else begin
         line_count_ff <= line_count_in;
         text_length_ff <= text_length_in;
         nonblank_end_ff <= nonblank_end_in;
         zero_seen_ff <= zero_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_wr) begin
         head_ff[text_length_ff[HEAD_IDX_W-1:0]] <= rx_byte;
      end
   end

endmodule

@@ rtl/core/fsr_queue.sv @@
// result queue: takes up to two words per cycle, hands out one per cycle while out_ready is high
`timescale 1ns / 1ps

module fsr_queue (
   input  logic               clock,
   input  logic               reset,
   input  fsr_pkg::push_type  push,
   output logic               room,
   output logic               out_valid,
   input  logic               out_ready,
   output fsr_pkg::result_type out_word
);
   import fsr_pkg::*;

   result_type q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ff, wr_in;
   logic [Q_PTR_W-1:0] rd_ff, rd_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic [Q_PTR_W-1:0] wr_next;
   logic pop;

   always_comb begin
      room = count_ff <= Q_CNT_W'(Q_DEPTH - 2);
      out_valid = (count_ff != '0);
      out_word = q_ff[rd_ff];
      pop = out_valid && out_ready;
      wr_next = wr_ff + 1'b1;
      wr_in = wr_ff + Q_PTR_W'(push.n);
      rd_in = rd_ff + Q_PTR_W'(pop);
      count_in = count_ff + Q_CNT_W'(push.n) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         q_ff[wr_ff] <= push.w0;
      end
      if (push.n == 2'd2) begin
         q_ff[wr_next] <= push.w1;
      end
   end

endmodule

@@ rtl/core/fall_token_stream_recognizer.sv @@
// top level: status flags, counters and result assembly of the recognizer
// One received byte is taken per cycle while req_ready is high. The stream scanner and the
// line parser both look at the byte in the cycle it is accepted, and the status flags and
// counters settle in that same cycle. A byte gives zero, one or two result words (a stream hit
// first, then a line result) that go into a four-word result queue; rsp_valid is high from
// the cycle after a byte with a result word is taken. req_ready is high while the queue has
// two free words, so bytes flow at one per cycle as long as the result side takes words as
// fast as they come; the two words of one byte reach the result side one after the other.
`timescale 1ns / 1ps

module fall_token_stream_recognizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic        rsp_status_valid,
   output logic        rsp_fall_seen,
   output logic [31:0] rsp_frame_total,
   output logic [31:0] rsp_error_total,
   output logic        rsp_last_in_run
);
   import fsr_pkg::*;

   logic valid_ff, valid_in;
   logic fall_ff, fall_in;
   logic [COUNT_WIDTH-1:0] frame_ff, frame_in;
   logic [COUNT_WIDTH-1:0] error_ff, error_in;

   logic take;
   scan_res_type scan_res;
   line_res_type line_res;
   push_type push;
   result_type out_word;
   result_type s_word;
   result_type l_word;
   logic s_hit;
   logic l_emit;
   logic line_ok;
   logic line_err;
   logic [COUNT_WIDTH-1:0] frame_p1;
   logic [COUNT_WIDTH-1:0] frame_p2;

   assign take = req_valid && req_ready;

   fsr_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .rx_byte  (req_rx_byte),
      .scan_res (scan_res)
   );

   fsr_line u_line (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .rx_byte  (req_rx_byte),
      .line_res (line_res)
   );

   always_comb begin
      s_hit = scan_res.hit;
      l_emit = line_res.emit;
      line_ok = l_emit && (line_res.kind == EV_LINE_NORMAL || line_res.kind == EV_LINE_FALL);
      line_err = l_emit && !line_ok;
      frame_p1 = frame_ff + 1'b1;
      frame_p2 = frame_ff + 2'd2;

      // stream word
      s_word.kind = scan_res.fall ? EV_STREAM_FALL : EV_STREAM_NORMAL;
      s_word.status_valid = 1'b1;
      s_word.fall_seen = scan_res.fall;
      s_word.frame_total = OUT_COUNT_W'(frame_p1);
      s_word.error_total = OUT_COUNT_W'(error_ff);
      s_word.last_in_run = !l_emit;

      // state after the whole byte, also shown on the line word
      valid_in = valid_ff || s_hit || line_ok;
      if (line_ok) begin
         fall_in = (line_res.kind == EV_LINE_FALL);
         frame_in = s_hit ? frame_p2 : frame_p1;
      end else begin
         fall_in = s_hit ? scan_res.fall : fall_ff;
         frame_in = s_hit ? frame_p1 : frame_ff;
      end
      error_in = line_err ? error_ff + 1'b1 : error_ff;

      l_word.kind = line_res.kind;
      l_word.status_valid = valid_in;
      l_word.fall_seen = fall_in;
      l_word.frame_total = OUT_COUNT_W'(frame_in);
      l_word.error_total = OUT_COUNT_W'(error_in);
      l_word.last_in_run = 1'b1;

      push.w0 = s_hit ? s_word : l_word;
      push.w1 = l_word;
      if (!take) begin
         push.n = 2'd0;
      end else begin
         push.n = 2'(s_hit) + 2'(l_emit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         fall_ff <= 1'b0;
         frame_ff <= '0;
         error_ff <= '0;
      end else if (take) begin
         valid_ff <= valid_in;
         fall_ff <= fall_in;
         frame_ff <= frame_in;
         error_ff <= error_in;
      end
   end

   fsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_event_kind = out_word.kind;
   assign rsp_status_valid = out_word.status_valid;
   assign rsp_fall_seen = out_word.fall_seen;
   assign rsp_frame_total = out_word.frame_total;
   assign rsp_error_total = out_word.error_total;
   assign rsp_last_in_run = out_word.last_in_run;

endmodule

@@ tb/fall_token_stream_recognizer_tb.sv @@
// self-checking testbench for the fall token stream recognizer with its own event predictor
`timescale 1ns / 1ps

module fall_token_stream_recognizer_tb;
   import fsr_pkg::*;

   localparam int RUN_LIMIT = 1_500_000;
   localparam int RANDOM_BYTES = 450;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_kind;
   logic        rsp_status_valid;
   logic        rsp_fall_seen;
   logic [31:0] rsp_frame_total;
   logic [31:0] rsp_error_total;
   logic        rsp_last_in_run;

   fall_token_stream_recognizer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_status_valid  (rsp_status_valid),
      .rsp_fall_seen     (rsp_fall_seen),
      .rsp_frame_total   (rsp_frame_total),
      .rsp_error_total   (rsp_error_total),
      .rsp_last_in_run   (rsp_last_in_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // marker and line tokens
   string tag;
   string norm_marks[3];
   string fall_marks[2];
   string norm_words[5];
   string fall_words[3];

   // predictor state
   logic [7:0]  hist [HIST_DEPTH];
   int          hist_cnt = 0;
   logic [7:0]  win [HIST_DEPTH+1];
   int          win_n;
   logic [7:0]  head [HEAD_DEPTH];
   int          stored_cnt = 0;
   int          txt_len = 0;
   bit          nul_seen = 1'b0;
   int          trim_len = 0;
   bit          st_valid = 1'b0;
   bit          st_fall = 1'b0;
   logic [31:0] frames = '0;
   logic [31:0] errors = '0;

   result_type  expected_events[$];
   result_type  want_r;
   logic [7:0]  burst_q[$];

   int  mismatches = 0;
   int  words_checked = 0;
   int  kind_seen[6] = '{default: 0};
   int  bytes_sent = 0;
   int  cycles = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  holds_asked = 0;
   int  holds_served = 0;
   bit  calm_rx = 1'b0;
   bit  steady_send = 1'b0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] upcase(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'h20 : c;
   endfunction

   function automatic bit is_marker_char(input logic [7:0] u);
      return (u >= "A" && u <= "Z") || (u >= "0" && u <= "9") ||
             u == "," || u == ":" || u == "_" || u == "-";
   endfunction

   function automatic bit tail_is(input string tok);
      int n;
      bit ok;
      n = tok.len();
      ok = (n <= win_n);
      for (int i = 0; i < n && ok; i++) begin
         if (win[win_n - n + i] != tok[i]) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic bit head_is(input int len, input string tok);
      bit ok;
      ok = (len == tok.len()) && (len <= HEAD_DEPTH);
      for (int i = 0; i < len && ok; i++) begin
         if (upcase(head[i]) != upcase(tok[i])) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic result_type snapshot(input event_kind_type k);
      result_type r;
      r.kind = k;
      r.status_valid = st_valid;
      r.fall_seen = st_fall;
      r.frame_total = frames;
      r.error_total = errors;
      r.last_in_run = 1'b0;
      return r;
   endfunction

   function automatic string mix_case(input string s);
      string r;
      r = s;
      for (int i = 0; i < r.len(); i++) begin
         if (r[i] >= "A" && r[i] <= "Z" && $urandom_range(0, 1)) r[i] = r[i] + 8'h20;
      end
      return r;
   endfunction

   task automatic note_status(input bit fall);
      st_valid = 1'b1;
      st_fall = fall;
      frames = frames + 32'd1;
   endtask

   task automatic clear_line();
      stored_cnt = 0;
      txt_len = 0;
      nul_seen = 1'b0;
      trim_len = 0;
   endtask

   task automatic predict_events(input logic [7:0] b);
      logic [7:0]     u;
      result_type     outs[2];
      int             n;
      int             hit;
      event_kind_type kind;
      u = upcase(b);
      n = 0;
      hit = -1;
      if (is_marker_char(u)) begin
         win_n = (hist_cnt > HIST_DEPTH) ? HIST_DEPTH : hist_cnt;
         for (int i = 0; i < win_n; i++) win[i] = hist[HIST_DEPTH - win_n + i];
         win[win_n] = u;
         win_n++;
         foreach (norm_marks[i]) if (tail_is(norm_marks[i])) hit = 0;
         if (hit < 0) begin
            foreach (fall_marks[i]) if (tail_is(fall_marks[i])) hit = 1;
         end
         if (hit >= 0) begin
            note_status(hit == 1);
            for (int i = 0; i < HIST_DEPTH; i++) hist[i] = 8'h00;
            hist_cnt = 0;
            outs[n] = snapshot(hit == 1 ? EV_STREAM_FALL : EV_STREAM_NORMAL);
            n++;
         end else begin
            for (int i = 0; i < HIST_DEPTH - 1; i++) hist[i] = hist[i+1];
            hist[HIST_DEPTH-1] = u;
            hist_cnt = (win_n > HIST_DEPTH) ? HIST_DEPTH : win_n;
         end
      end
      if (b == CHAR_LF) begin
         if (txt_len > 0) begin
            kind = EV_LINE_UNKNOWN;
            foreach (norm_words[i]) if (head_is(trim_len, norm_words[i])) kind = EV_LINE_NORMAL;
            if (kind == EV_LINE_UNKNOWN) begin
               foreach (fall_words[i]) if (head_is(trim_len, fall_words[i])) kind = EV_LINE_FALL;
            end
            if (kind == EV_LINE_UNKNOWN) errors = errors + 32'd1;
            else note_status(kind == EV_LINE_FALL);
            outs[n] = snapshot(kind);
            n++;
         end
         clear_line();
      end else if (b != CHAR_CR) begin
         if (stored_cnt + 1 < LINE_LIMIT) begin
            stored_cnt++;
            if (b == CHAR_NUL) begin
               nul_seen = 1'b1;
            end else if (!nul_seen) begin
               if (txt_len < HEAD_DEPTH) head[txt_len] = b;
               txt_len++;
               if (b != CHAR_SPACE && b != CHAR_TAB) trim_len = txt_len;
            end
         end else begin
            clear_line();
            errors = errors + 32'd1;
            outs[n] = snapshot(EV_LINE_TOO_LONG);
            n++;
         end
      end
      if (n > 0) begin
         outs[n-1].last_in_run = 1'b1;
         for (int i = 0; i < n; i++) expected_events.push_back(outs[i]);
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = steady_send ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_events(b);
      bytes_sent++;
   endtask

   task automatic add_byte(input logic [7:0] b);
      burst_q.push_back(b);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) burst_q.push_back(s[i]);
   endtask

   task automatic add_noise(input int n);
      repeat (n) burst_q.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic flush_burst();
      while (burst_q.size() > 0) send_byte(burst_q.pop_front());
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < 40) begin
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
      end
      mismatches++;
   endtask

   // result side: random stalls, calm stretches and a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES - 1;
         holds_served <= holds_asked;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm_rx && $urandom_range(0, 99) < 30) stall_left <= pick_gap();
      end
      if ($urandom_range(0, 249) == 0) calm_rx <= !calm_rx;
   end

   // result word checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            report_mismatch("word with nothing pending, kind", 32'(rsp_event_kind), 32'd0);
         end else begin
            want_r = expected_events.pop_front();
            if (rsp_event_kind !== want_r.kind)
               report_mismatch("event_kind", 32'(rsp_event_kind), 32'(want_r.kind));
            if (rsp_status_valid !== want_r.status_valid)
               report_mismatch("status_valid", 32'(rsp_status_valid),
                               32'(want_r.status_valid));
            if (rsp_fall_seen !== want_r.fall_seen)
               report_mismatch("fall_seen", 32'(rsp_fall_seen), 32'(want_r.fall_seen));
            if (rsp_frame_total !== want_r.frame_total)
               report_mismatch("frame_total", rsp_frame_total, want_r.frame_total);
            if (rsp_error_total !== want_r.error_total)
               report_mismatch("error_total", rsp_error_total, want_r.error_total);
            if (rsp_last_in_run !== want_r.last_in_run)
               report_mismatch("last_in_run", 32'(rsp_last_in_run), 32'(want_r.last_in_run));
            kind_seen[int'(want_r.kind)]++;
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == RUN_LIMIT) begin
         $display("timeout with %0d words pending", expected_events.size());
         $display("fall_token_stream_recognizer verification failed");
         $finish;
      end
   end

   task automatic test_line_tokens();
      foreach (norm_words[i]) begin
         add_str(norm_words[i]);
         add_byte(CHAR_LF);
      end
      foreach (fall_words[i]) begin
         add_str(fall_words[i]);
         add_byte(CHAR_LF);
      end
      add_str("fall \t\r\n");
      add_str("nOrMaL\n");
      flush_burst();
   endtask

   task automatic test_stream_markers();
      add_str({"xx", norm_marks[0]});
      add_str({"q", mix_case(norm_marks[1])});
      add_str({tag, ", 0"});
      add_str(fall_marks[0].tolower());
      add_str(tag);
      add_byte(",");
      add_byte(8'hFF);
      add_str("1");
      add_str({tag, "X,1"});
      add_str("\r\n");
      flush_burst();
   endtask

   task automatic test_line_corner_cases();
      add_str("\n\r\n \t\n");
      add_byte(CHAR_NUL);
      add_str("FALL\n");
      add_str("FALL");
      add_byte(CHAR_NUL);
      add_str("xyz\n1 \n 1\n");
      add_str({norm_marks[0], "X\n"});
      add_byte(8'h80);
      add_byte(8'hFF);
      add_byte(8'hE1);
      add_str("`{@[/;\n");
      add_byte(8'h7F);
      add_str("az09AZ\n");
      flush_burst();
   endtask

   task automatic test_line_overflow();
      // the byte that overflows the line also completes a stream marker
      repeat (LINE_LIMIT - 1 - (tag.len() + 1)) add_byte(CHAR_SPACE);
      add_str({tag, ","});
      add_str("1\n");
      for (int i = 0; i < LINE_LIMIT + 10; i++) begin
         add_byte((i % 3 == 0) ? CHAR_NUL : "x");
         if (i % 50 == 0) add_byte(CHAR_CR);
      end
      add_str("\n0\n");
      flush_burst();
   endtask

   task automatic test_backpressure();
      holds_asked++;
      steady_send = 1'b1;
      repeat (30) add_str("1\n");
      flush_burst();
      steady_send = 1'b0;
   endtask

   task automatic test_random_traffic();
      int    rand_bytes;
      int    pick;
      string tok;
      rand_bytes = 0;
      while (rand_bytes < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 40) == 0) steady_send = !steady_send;
         tok = $urandom_range(0, 1) ? norm_words[$urandom_range(0, 4)]
                                    : fall_words[$urandom_range(0, 2)];
         if (pick < 35) begin
            add_str(mix_case(tok));
            if ($urandom_range(0, 3) == 0) begin
               add_byte(CHAR_NUL);
               add_noise($urandom_range(0, 3));
            end
            repeat ($urandom_range(0, 2)) add_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
            if ($urandom_range(0, 1)) add_byte(CHAR_CR);
            add_byte(CHAR_LF);
         end else if (pick < 55) begin
            add_noise($urandom_range(0, 4));
            tok = $urandom_range(0, 1) ? norm_marks[$urandom_range(0, 2)]
                                       : fall_marks[$urandom_range(0, 1)];
            tok = mix_case(tok);
            for (int i = 0; i < tok.len(); i++) begin
               add_byte(tok[i]);
               if ($urandom_range(0, 7) == 0) begin
                  case ($urandom_range(0, 5))
                     0: add_byte(CHAR_SPACE);
                     1: add_byte(".");
                     2: add_byte(8'hC6);
                     3: add_byte(CHAR_TAB);
                     4: add_byte(CHAR_CR);
                     default: add_byte(CHAR_NUL);
                  endcase
               end
            end
            if ($urandom_range(0, 2) == 0) add_byte(CHAR_LF);
         end else if (pick < 70) begin
            // broken tokens: cut short or with a stray character
            if (tok.len() > 1 && $urandom_range(0, 1)) begin
               tok = tok.substr(0, $urandom_range(0, tok.len() - 2));
            end else if ($urandom_range(0, 1)) begin
               tok = {tok, "X"};
            end else begin
               tok = {"-", tok};
            end
            add_str(mix_case(tok));
            add_byte(CHAR_LF);
         end else if (pick < 80) begin
            case ($urandom_range(0, 3))
               0: add_byte(CHAR_LF);
               1: add_str("\r\n");
               2: begin
                  repeat ($urandom_range(1, 4))
                     add_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
                  add_byte(CHAR_LF);
               end
               default: begin
                  add_byte(CHAR_NUL);
                  add_str("FALL\n");
               end
            endcase
         end else begin
            add_noise($urandom_range(1, 8));
         end
         rand_bytes += burst_q.size();
         flush_burst();
      end
      steady_send = 1'b0;
   endtask

   initial begin
      tag = $sformatf("%c%c%c%c", MARK_PREFIX[31:24], MARK_PREFIX[23:16],
                      MARK_PREFIX[15:8], MARK_PREFIX[7:0]);
      norm_marks = '{{tag, ",NOFALL"}, {tag, ",NORMAL"}, {tag, ",0"}};
      fall_marks = '{{tag, ",FALL"}, {tag, ",1"}};
      norm_words = '{{tag, ",NOFALL"}, "NOFALL", {tag, ",NORMAL"}, "NORMAL", "0"};
      fall_words = '{{tag, ",FALL"}, "FALL", "1"};
      for (int i = 0; i < HIST_DEPTH; i++) hist[i] = 8'h00;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_line_tokens();
      test_stream_markers();
      test_line_corner_cases();
      test_line_overflow();
      test_backpressure();
      test_random_traffic();

      req_valid <= 1'b0;
      while (expected_events.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d bytes, checked %0d result words, %0d mismatches",
               bytes_sent, words_checked, mismatches);
      $display("stream normal/fall %0d/%0d, line normal/fall %0d/%0d, unknown %0d, overlong %0d",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
               kind_seen[5]);
      if (mismatches == 0) begin
         $display("fall_token_stream_recognizer verification clean");
      end else begin
         $display("fall_token_stream_recognizer verification failed");
      end
      $finish;
   end

endmodule

@@ fall_token_stream_recognizer.f @@
rtl/core/fsr_pkg.sv
rtl/core/fsr_scan.sv
rtl/core/fsr_line.sv
rtl/core/fsr_queue.sv
rtl/core/fall_token_stream_recognizer.sv
tb/fall_token_stream_recognizer_tb.sv
